[src/stt_pkg.sv]
package stt_pkg;

  // one input word: a document byte and its end flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_t;

  // one output word
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] token_byte;
    logic [2:0] delimiter_class;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [2:0] DELIM_FILE_START = 3'd0;
  localparam logic [2:0] DELIM_SPACE      = 3'd1;
  localparam logic [2:0] DELIM_BLOCK      = 3'd2;
  localparam logic [2:0] DELIM_SINGLE     = 3'd3;
  localparam logic [2:0] DELIM_DOUBLE     = 3'd4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [2:0] cls;
  } res_entry_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]                        count;
    res_entry_t [MAX_RESULTS-1:0]      item;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_VT);
  endfunction

endpackage

[src/stt_front.sv]
module stt_front
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  in_t       text,
  input  q_status_t q_status,
  output logic      push,
  output bundle_t   bundle
);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_BARE    = 5'b00100,
    MODE_BLOCK   = 5'b01000,
    MODE_QUOTE   = 5'b10000
  } mode_t;

  typedef enum logic [2:0] {
    HOLD_NONE  = 3'b001,
    HOLD_SEMI  = 3'b010,
    HOLD_QUOTE = 3'b100
  } hold_t;

  mode_t      mode, mode_next;
  hold_t      hold, hold_next;
  logic [2:0] delim, delim_next;
  logic       prev_nl;
  logic       seen;

  logic                         accept;
  logic [7:0]                   b;
  logic                         eod;
  logic                         sp;
  logic [7:0]                   qc;
  logic [2:0]                   start_cls;
  logic                         bare_go;
  logic [1:0]                   n;
  res_entry_t [MAX_RESULTS-1:0] item;

  function automatic res_entry_t entry(kind_t k, logic [7:0] v);
    res_entry_t e;
    e.kind = k;
    e.data = v;
    e.cls  = DELIM_FILE_START;
    return e;
  endfunction

  assign text_stall = q_status.full;
  assign accept     = text_valid && !q_status.full;
  assign b          = text.data_byte;
  assign eod        = text.end_of_data;
  assign sp         = is_space(b);
  assign qc         = (delim == DELIM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
  assign start_cls  = seen ? DELIM_SPACE : DELIM_FILE_START;

  always_comb begin
    mode_next  = mode;
    hold_next  = hold;
    delim_next = delim;
    bare_go    = 1'b0;
    n          = 2'd0;
    item       = '0;
    unique case (mode)
      MODE_COMMENT: begin
        if (b == CH_NL) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_BARE: begin
        if (sp) begin
          item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          item[n] = entry(KIND_BYTE, b); n = n + 2'd1;
          if (eod) begin
            item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
          end
        end
      end
      MODE_BLOCK: begin
        if (b == CH_SEMI && prev_nl) begin
          item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          item[n] = entry(KIND_BYTE, b); n = n + 2'd1;
          if (eod) begin
            item[n] = entry(KIND_ERROR, 8'd0); n = n + 2'd1;
          end
        end
      end
      MODE_QUOTE: begin
        if (hold == HOLD_QUOTE && sp) begin
          hold_next = HOLD_NONE;
          item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          // held quote turned out to be content
          if (hold == HOLD_QUOTE) begin
            hold_next = HOLD_NONE;
            item[n] = entry(KIND_BYTE, qc); n = n + 2'd1;
          end
          if (b == qc) begin
            if (eod) begin
              item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
            end else begin
              hold_next = HOLD_QUOTE;
            end
          end else begin
            item[n] = entry(KIND_BYTE, b); n = n + 2'd1;
            if (eod) begin
              item[n] = entry(KIND_ERROR, 8'd0); n = n + 2'd1;
            end
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        hold_next = HOLD_NONE;
        if (hold == HOLD_SEMI) begin
          if (b == CH_NL) begin
            delim_next = DELIM_BLOCK;
            mode_next  = MODE_BLOCK;
            if (eod) begin
              item[n] = entry(KIND_ERROR, 8'd0); n = n + 2'd1;
            end
          end else begin
            item[n] = entry(KIND_BYTE, CH_SEMI); n = n + 2'd1;
            bare_go = 1'b1;
          end
        end else if (sp) begin
          mode_next = MODE_IDLE;
        end else if (b == CH_HASH) begin
          mode_next = MODE_COMMENT;
        end else if (b == CH_SEMI) begin
          delim_next = start_cls;
          if (eod) begin
            item[n] = entry(KIND_BYTE, CH_SEMI); n = n + 2'd1;
            item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
          end else begin
            hold_next = HOLD_SEMI;
          end
        end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
          delim_next = (b == CH_SQUOTE) ? DELIM_SINGLE : DELIM_DOUBLE;
          mode_next  = MODE_QUOTE;
          if (eod) begin
            item[n] = entry(KIND_ERROR, 8'd0); n = n + 2'd1;
          end
        end else begin
          delim_next = start_cls;
          bare_go    = 1'b1;
        end
        if (bare_go) begin
          mode_next = MODE_BARE;
          if (sp) begin
            item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
            mode_next = MODE_IDLE;
          end else begin
            item[n] = entry(KIND_BYTE, b); n = n + 2'd1;
            if (eod) begin
              item[n] = entry(KIND_END, 8'd0); n = n + 2'd1;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    bundle.count = n;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bundle.item[i]     = item[i];
      bundle.item[i].cls = delim_next;
    end
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      hold    <= HOLD_NONE;
      delim   <= DELIM_FILE_START;
      prev_nl <= 1'b0;
      seen    <= 1'b0;
    end else if (accept) begin
      if (eod) begin
        mode    <= MODE_IDLE;
        hold    <= HOLD_NONE;
        delim   <= DELIM_FILE_START;
        prev_nl <= 1'b0;
        seen    <= 1'b0;
      end else begin
        mode    <= mode_next;
        hold    <= hold_next;
        delim   <= delim_next;
        prev_nl <= (b == CH_NL);
        seen    <= 1'b1;
      end
    end
  end

endmodule

[src/stt_queue.sv]
module stt_queue
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bundle_t   wdata,
  input  logic      pop,
  output bundle_t   head,
  output q_status_t status
);

  bundle_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/stt_back.sv]
module stt_back
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bundle_t   head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      token_valid,
  input  logic      token_stall,
  output out_t      token
);

  logic [1:0] idx;
  logic       last;
  logic       fire;
  res_entry_t cur;

  assign cur         = head.item[idx];
  assign last        = (idx == head.count - 2'd1);
  assign token_valid = !q_status.empty;
  assign fire        = token_valid && !token_stall;
  assign pop         = fire && last;

  assign token.result_kind     = cur.kind;
  assign token.token_byte      = cur.data;
  assign token.delimiter_class = cur.cls;
  assign token.last            = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

[src/star_text_tokenizer.sv]
// star text tokenizer: splits a document byte stream into tokens
// text channel: one document byte per word with end_of_data on the final byte;
//   a word is taken at a rising edge with text_valid high and text_stall low
// token channel: one result per word (content byte, token end or error), with
//   the token's delimiter class and last set on the final result of its byte
// a front scanner classifies each byte in the cycle it is taken and writes the
//   results it causes (none to three) into a four-entry queue; a back stage
//   hands them out one per cycle while token_stall is low
// a byte's results are registered in the queue ahead of the token channel
// throughput: one byte per cycle while bytes give at most one result each and
//   token_stall stays low; a byte giving two or three results puts each of them
//   out in turn, and text_stall rises only once the queue is full
// bytes giving no result (whitespace, comments, an opening quote) push nothing
// reset: queue empty, scanner between tokens at document start, no word valid
// token_stall: the current word holds steady, the queue fills, then text_stall
// end_of_data returns the scanner to its reset state for the next document
module star_text_tokenizer
  import stt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic text_valid,
  output logic text_stall,
  input  in_t  text,
  output logic token_valid,
  input  logic token_stall,
  output out_t token
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  bundle_t   push_bundle;
  bundle_t   head;

  // scanner: mode, held candidate and delimiter class
  stt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .q_status   (q_status),
    .push       (push),
    .bundle     (push_bundle)
  );

  // per-byte result groups between scanner and output
  stt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_bundle),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  // serializes one group onto the token channel
  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

endmodule
